### rtl/core/gcov_pkg.sv
// Shared types, constants and helpers for the splat covariance pipeline.
`timescale 1ns / 1ps

package gcov_pkg;

   localparam int NumRot  = 9;   // rotation / scaled-rotation entries, row major
   localparam int NumAxis = 3;
   localparam int NumCov  = 6;   // unique covariance entries

   typedef logic        [15:0] scale_type;   // unsigned Q2.14
   typedef logic signed [15:0] quat_type;    // signed Q1.15
   typedef logic signed [31:0] qprod_type;   // quaternion product, Q2.30
   typedef logic signed [33:0] rot_type;     // rotation entry, Q.30
   typedef logic signed [50:0] mraw_type;    // rot * scale, Q.44
   typedef logic signed [29:0] mel_type;     // scaled rotation entry, Q.24
   typedef logic signed [59:0] mprod_type;   // product of two M entries, Q.48
   typedef logic signed [61:0] acc_type;     // three-term sum, Q.48
   typedef logic signed [31:0] cov_type;     // covariance, Q5.26

   localparam rot_type  Q30One   = 34'sh4000_0000;
   localparam mraw_type MHalf    = 51'sh8_0000;         // 2^19
   localparam acc_type  CovHalf  = 62'sh20_0000;        // 2^21
   localparam int       MShift   = 20;
   localparam int       CovShift = 22;

   // column-of-M indexes of the two factors of each covariance entry
   localparam int PairI [NumCov] = '{0, 0, 0, 1, 1, 2};
   localparam int PairJ [NumCov] = '{0, 1, 2, 1, 2, 2};

   // round half up from Q.44 to Q.24; magnitude stays below 2^28
   function automatic mel_type round_m(input mraw_type p);
      mraw_type t;
      t = p + MHalf;
      return t[MShift+29:MShift];
   endfunction

   // round half up from Q.48 to Q.26, then clamp to 32 bits
   function automatic cov_type round_sat(input acc_type a);
      acc_type             t;
      logic signed [39:0]  r;
      t = a + CovHalf;
      r = t[61:CovShift];
      if (r > 40'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (r < -40'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return r[31:0];
   endfunction

endpackage

### rtl/core/gaussian_covariance_from_scale_rot.sv
// Top level: 3D Gaussian splat covariance from axis scales and a rotation quaternion.
//
// Usage:
//  - Request: drive req_scale_* (unsigned Q2.14) and req_quat_* (signed Q1.15)
//    with start high; the word is taken at a rising edge where start is high
//    and busy is low. busy is held low: the pipeline takes one word per cycle.
//  - Response: six unique covariance entries (signed Q5.26, clamped to 32 bits)
//    appear on rsp_cov_* for exactly one cycle with rsp_valid high.
//  - Throughput: one splat per cycle, sustained.
//  - Stages: 1 quaternion products, 2 rotation entries, 3 row scaling
//    multiply, 4 rounding to Q.24, 5 pairwise products of M, 6 three-term sum,
//    rounding to Q.26 and saturation. The 34 x 17 and 30 x 30 multiplies each
//    get a stage of their own.
//  - Reset (synchronous, active high) clears the stage valid bits; words in
//    flight are dropped, data registers are not cleared.
//  - The receiver cannot stall, so the pipeline never holds; each response
//    word must be taken in the cycle it is shown.
`timescale 1ns / 1ps

module gaussian_covariance_from_scale_rot (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  gcov_pkg::scale_type  req_scale_x,
   input  gcov_pkg::scale_type  req_scale_y,
   input  gcov_pkg::scale_type  req_scale_z,
   input  gcov_pkg::quat_type   req_quat_w,
   input  gcov_pkg::quat_type   req_quat_x,
   input  gcov_pkg::quat_type   req_quat_y,
   input  gcov_pkg::quat_type   req_quat_z,
   output logic                 rsp_valid,
   output gcov_pkg::cov_type    rsp_cov_xx,
   output gcov_pkg::cov_type    rsp_cov_xy,
   output gcov_pkg::cov_type    rsp_cov_xz,
   output gcov_pkg::cov_type    rsp_cov_yy,
   output gcov_pkg::cov_type    rsp_cov_yz,
   output gcov_pkg::cov_type    rsp_cov_zz
);
   import gcov_pkg::*;

   logic      req_accept;
   scale_type req_scale [NumAxis];

   logic      rot_valid;
   scale_type rot_scale [NumAxis];
   rot_type   rot [NumRot];

   logic      m_valid;
   mel_type   m [NumRot];

   cov_type   cov [NumCov];

   // never back-pressures
   assign busy       = 1'b0;
   assign req_accept = start & ~busy;

   assign req_scale[0] = req_scale_x;
   assign req_scale[1] = req_scale_y;
   assign req_scale[2] = req_scale_z;

   // stages 1-2
   gcov_rot u_rot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_scale  (req_scale),
      .quat_w    (req_quat_w),
      .quat_x    (req_quat_x),
      .quat_y    (req_quat_y),
      .quat_z    (req_quat_z),
      .out_valid (rot_valid),
      .out_scale (rot_scale),
      .out_rot   (rot)
   );

   // stages 3-4
   gcov_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid),
      .in_scale  (rot_scale),
      .in_rot    (rot),
      .out_valid (m_valid),
      .out_m     (m)
   );

   // stages 5-6, output registers live here
   gcov_gram u_gram (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m_valid),
      .in_m      (m),
      .out_valid (rsp_valid),
      .out_cov   (cov)
   );

   assign rsp_cov_xx = cov[0];
   assign rsp_cov_xy = cov[1];
   assign rsp_cov_xz = cov[2];
   assign rsp_cov_yy = cov[3];
   assign rsp_cov_yz = cov[4];
   assign rsp_cov_zz = cov[5];

   // every accepted word produces a response
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##6 rsp_valid)
      else $error("accepted word did not produce a response");

   // no response without a matching earlier request
   a_no_ghost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 6))
      else $error("response without a request");

   // diagonal entries are sums of squares
   a_diag_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_cov_xx[31] && !rsp_cov_yy[31] && !rsp_cov_zz[31]))
      else $error("negative diagonal covariance entry");

endmodule

### rtl/core/gcov_rot.sv
// Quaternion to rotation matrix: products stage, then sum stage.
`timescale 1ns / 1ps

module gcov_rot (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  gcov_pkg::scale_type  in_scale [gcov_pkg::NumAxis],
   input  gcov_pkg::quat_type   quat_w,
   input  gcov_pkg::quat_type   quat_x,
   input  gcov_pkg::quat_type   quat_y,
   input  gcov_pkg::quat_type   quat_z,
   output logic                 out_valid,
   output gcov_pkg::scale_type  out_scale [gcov_pkg::NumAxis],
   output gcov_pkg::rot_type    out_rot [gcov_pkg::NumRot]
);
   import gcov_pkg::*;

   logic      v1_ff, v2_ff;
   scale_type s1_ff [NumAxis];
   scale_type s2_ff [NumAxis];
   qprod_type xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   rot_type   rot_in [NumRot];
   rot_type   rot_ff [NumRot];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   // stage 1: the nine Q2.30 products
   always_ff @(posedge clock) begin
      s1_ff <= in_scale;
      xx_ff <= quat_x * quat_x;
      yy_ff <= quat_y * quat_y;
      zz_ff <= quat_z * quat_z;
      xy_ff <= quat_x * quat_y;
      xz_ff <= quat_x * quat_z;
      yz_ff <= quat_y * quat_z;
      wx_ff <= quat_w * quat_x;
      wy_ff <= quat_w * quat_y;
      wz_ff <= quat_w * quat_z;
   end

   // stage 2: R entries, exact in 34 bits
   always_comb begin
      rot_in[0] = Q30One - ((34'(yy_ff) + 34'(zz_ff)) <<< 1);
      rot_in[1] = (34'(xy_ff) - 34'(wz_ff)) <<< 1;
      rot_in[2] = (34'(xz_ff) + 34'(wy_ff)) <<< 1;
      rot_in[3] = (34'(xy_ff) + 34'(wz_ff)) <<< 1;
      rot_in[4] = Q30One - ((34'(xx_ff) + 34'(zz_ff)) <<< 1);
      rot_in[5] = (34'(yz_ff) - 34'(wx_ff)) <<< 1;
      rot_in[6] = (34'(xz_ff) - 34'(wy_ff)) <<< 1;
      rot_in[7] = (34'(yz_ff) + 34'(wx_ff)) <<< 1;
      rot_in[8] = Q30One - ((34'(xx_ff) + 34'(yy_ff)) <<< 1);
   end

   always_ff @(posedge clock) begin
      s2_ff  <= s1_ff;
      rot_ff <= rot_in;
   end

   assign out_valid = v2_ff;
   assign out_scale = s2_ff;
   assign out_rot   = rot_ff;

endmodule

### rtl/core/gcov_scale.sv
// Row scaling M = S * R: multiply stage, then rounding stage.
`timescale 1ns / 1ps

module gcov_scale (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  gcov_pkg::scale_type  in_scale [gcov_pkg::NumAxis],
   input  gcov_pkg::rot_type    in_rot [gcov_pkg::NumRot],
   output logic                 out_valid,
   output gcov_pkg::mel_type    out_m [gcov_pkg::NumRot]
);
   import gcov_pkg::*;

   logic     v3_ff, v4_ff;
   mraw_type raw_ff [NumRot];
   mel_type  m_ff [NumRot];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v3_ff <= in_valid;
         v4_ff <= v3_ff;
      end
   end

   // 34 x 17 signed multiply per entry; entry k lies in row k / NumAxis and uses that row's scale
   always_ff @(posedge clock) begin
      for (int k = 0; k < NumRot; k++) begin
         raw_ff[k] <= 51'(in_rot[k]) * 51'($signed({1'b0, in_scale[k / NumAxis]}));
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NumRot; k++) begin
         m_ff[k] <= round_m(raw_ff[k]);
      end
   end

   assign out_valid = v4_ff;
   assign out_m     = m_ff;

endmodule

### rtl/core/gcov_gram.sv
// Covariance M^T * M: pairwise products stage, then sum/round/saturate stage.
`timescale 1ns / 1ps

module gcov_gram (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  gcov_pkg::mel_type    in_m [gcov_pkg::NumRot],
   output logic                 out_valid,
   output gcov_pkg::cov_type    out_cov [gcov_pkg::NumCov]
);
   import gcov_pkg::*;

   logic      v5_ff, v6_ff;
   mprod_type pp_ff [NumCov][NumAxis];
   cov_type   cov_ff [NumCov];
   acc_type   acc [NumCov];

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v5_ff <= in_valid;
         v6_ff <= v5_ff;
      end
   end

   // 18 products of 30 x 30 bits
   always_ff @(posedge clock) begin
      for (int e = 0; e < NumCov; e++) begin
         for (int k = 0; k < NumAxis; k++) begin
            pp_ff[e][k] <= 60'(in_m[NumAxis * k + PairI[e]])
                         * 60'(in_m[NumAxis * k + PairJ[e]]);
         end
      end
   end

   always_comb begin
      for (int e = 0; e < NumCov; e++) begin
         acc[e] = 62'(pp_ff[e][0]) + 62'(pp_ff[e][1]) + 62'(pp_ff[e][2]);
      end
   end

   always_ff @(posedge clock) begin
      for (int e = 0; e < NumCov; e++) begin
         cov_ff[e] <= round_sat(acc[e]);
      end
   end

   assign out_valid = v6_ff;
   assign out_cov   = cov_ff;

endmodule
